@@ rtl/esd_pkg.sv @@
package esd_pkg;

    // Default width of the running output counter.
    localparam int COUNT_BITS_DEF = 16;

    // Width of the count field carried on the result channel.
    localparam int OUT_COUNT_W = 16;

    // Number of entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Character codes that the decoder produces or recognises.
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;

    typedef struct packed {
        logic [7:0] in_char;
        logic       is_final;
    } t_in;

    typedef struct packed {
        logic [7:0]             out_char;
        logic                   run_last;
        logic [OUT_COUNT_W-1:0] out_count;
    } t_out;

    // One decoded request: a single byte, or a CR followed by an LF.
    typedef struct packed {
        logic [7:0]             char0;
        logic [OUT_COUNT_W-1:0] cnt0;
        logic                   two;
        logic [OUT_COUNT_W-1:0] cnt1;
    } t_entry;

endpackage

@@ rtl/esd_front.sv @@
module esd_front #(
    parameter int COUNT_BITS = esd_pkg::COUNT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  esd_pkg::t_in  i_in_data,
    input  logic          i_q_full,
    output logic          o_q_push,
    output esd_pkg::t_entry o_q_data
);

    localparam logic [3:0] PH_PLAIN = 4'd0;
    localparam logic [3:0] PH_ESC   = 4'd1;
    localparam logic [3:0] PH_HEX1  = 4'd2;
    localparam logic [3:0] PH_HEX2  = 4'd3;
    localparam logic [3:0] PH_DEC1  = 4'd4;
    localparam logic [3:0] PH_DEC2  = 4'd5;
    localparam logic [3:0] PH_DEC3  = 4'd6;

    localparam int EXT_W = (COUNT_BITS > esd_pkg::OUT_COUNT_W) ? COUNT_BITS
                                                                : esd_pkg::OUT_COUNT_W;

    // Returns the hex digit value, or 16 when the byte is not a hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            u = c - 8'h20;
        end
        if (u >= 8'h30 && u <= 8'h39) begin
            hex_val = 5'(u - 8'h30);
        end else if (u >= 8'h41 && u <= 8'h46) begin
            hex_val = 5'(u - 8'h37);
        end else begin
            hex_val = 5'd16;
        end
    endfunction

    // Returns the decimal digit value, or 10 when the byte is not a digit.
    function automatic logic [3:0] dec_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            dec_val = 4'(c - 8'h30);
        end else begin
            dec_val = 4'd10;
        end
    endfunction

    logic [3:0]            r_phase,   n_phase;
    logic [9:0]            r_partial, n_partial;
    logic                  r_bad,     n_bad;
    logic [COUNT_BITS-1:0] r_emitted, n_emitted;

    logic [7:0]            c;
    logic                  fin;
    logic [4:0]            hv;
    logic [3:0]            dv;
    logic [10:0]           code;
    logic [1:0]            n_emit;
    logic [7:0]            ch0;
    logic                  lone_bs;
    logic [COUNT_BITS-1:0] cnt1, cnt2;
    logic [EXT_W-1:0]      ext1, ext2;
    logic                  accept;

    assign c      = i_in_data.in_char;
    assign fin    = i_in_data.is_final;
    assign hv     = hex_val(c);
    assign dv     = dec_val(c);
    assign code   = 11'(r_partial) + 11'(dv);
    assign accept = i_in_valid && o_in_ready;

    assign o_in_ready = !i_q_full;

    always_comb begin
        n_phase   = r_phase;
        n_partial = r_partial;
        n_bad     = r_bad;
        n_emit    = 2'd0;
        ch0       = c;
        lone_bs   = 1'b0;
        unique case (r_phase)
            PH_PLAIN: begin
                if (c == esd_pkg::CH_BACKSLASH) begin
                    n_phase = PH_ESC;
                    lone_bs = 1'b1;
                end else begin
                    n_emit = 2'd1;
                end
            end
            PH_ESC: begin
                n_phase   = PH_PLAIN;
                n_bad     = 1'b0;
                n_partial = 10'd0;
                priority if (c == esd_pkg::CH_BACKSLASH || c == esd_pkg::CH_QUOTE) begin
                    n_emit = 2'd1;
                end else if (c == 8'h6E || c == 8'h4E) begin
                    n_emit = 2'd2;
                    ch0    = esd_pkg::CH_CR;
                end else if (c == 8'h74 || c == 8'h54) begin
                    n_emit = 2'd1;
                    ch0    = esd_pkg::CH_TAB;
                end else if (c == 8'h78 || c == 8'h58) begin
                    n_phase = PH_HEX1;
                end else if (c == 8'h69 || c == 8'h49) begin
                    n_phase = PH_DEC1;
                end else begin
                    n_phase = PH_PLAIN;
                end
            end
            PH_HEX1: begin
                if (hv[4]) begin
                    n_bad = 1'b1;
                end else begin
                    n_partial = {6'd0, hv[3:0]};
                end
                n_phase = PH_HEX2;
            end
            PH_HEX2: begin
                if (!r_bad && !hv[4]) begin
                    n_emit = 2'd1;
                    ch0    = {r_partial[3:0], hv[3:0]};
                end
                n_phase = PH_PLAIN;
            end
            PH_DEC1: begin
                if (dv > 4'd9) begin
                    n_bad = 1'b1;
                end else begin
                    n_partial = 10'(dv) * 10'd100;
                end
                n_phase = PH_DEC2;
            end
            PH_DEC2: begin
                if (dv > 4'd9) begin
                    n_bad = 1'b1;
                end else if (!r_bad) begin
                    n_partial = r_partial + 10'(dv) * 10'd10;
                end
                n_phase = PH_DEC3;
            end
            PH_DEC3: begin
                if (!r_bad && dv <= 4'd9 && code < 11'd256) begin
                    n_emit = 2'd1;
                    ch0    = code[7:0];
                end
                n_phase = PH_PLAIN;
            end
            default: begin
                n_phase = PH_PLAIN;
            end
        endcase

        if (fin) begin
            if (lone_bs) begin
                n_emit = 2'd1;
                ch0    = esd_pkg::CH_BACKSLASH;
            end
            n_phase   = PH_PLAIN;
            n_partial = 10'd0;
            n_bad     = 1'b0;
        end
    end

    // Saturating counts for the first and second byte of this request.
    assign cnt1 = (&r_emitted) ? r_emitted : r_emitted + 1'b1;
    assign cnt2 = (&cnt1) ? cnt1 : cnt1 + 1'b1;
    assign ext1 = EXT_W'(cnt1);
    assign ext2 = EXT_W'(cnt2);

    always_comb begin
        if (fin) begin
            n_emitted = '0;
        end else if (n_emit == 2'd2) begin
            n_emitted = cnt2;
        end else if (n_emit == 2'd1) begin
            n_emitted = cnt1;
        end else begin
            n_emitted = r_emitted;
        end
    end

    assign o_q_push       = accept && (n_emit != 2'd0);
    assign o_q_data.char0 = ch0;
    assign o_q_data.cnt0  = ext1[esd_pkg::OUT_COUNT_W-1:0];
    assign o_q_data.two   = (n_emit == 2'd2);
    assign o_q_data.cnt1  = ext2[esd_pkg::OUT_COUNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_PLAIN;
            r_partial <= 10'd0;
            r_bad     <= 1'b0;
            r_emitted <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_partial <= n_partial;
            r_bad     <= n_bad;
            r_emitted <= n_emitted;
        end
    end

endmodule

@@ rtl/esd_queue.sv @@
module esd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  esd_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output esd_pkg::t_entry o_data
);

    localparam int PTR_W = $clog2(esd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(esd_pkg::QUEUE_DEPTH + 1);

    esd_pkg::t_entry r_mem [esd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(esd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(esd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(esd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push && !o_full) - CNT_W'(do_pop);
        end
    end

endmodule

@@ rtl/esd_back.sv @@
module esd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  esd_pkg::t_entry i_q_data,
    output logic            o_q_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output esd_pkg::t_out   o_out_data
);

    logic                               r_out_valid;
    esd_pkg::t_out                      r_out;
    logic                               r_pend;
    logic [esd_pkg::OUT_COUNT_W-1:0]    r_pend_cnt;
    logic                               load;

    // The output register takes a new result whenever it is empty or drained.
    assign load    = !r_out_valid || i_out_ready;
    assign o_q_pop = load && !r_pend && i_q_valid;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_out.out_char  <= esd_pkg::CH_LF;
                r_out.run_last  <= 1'b1;
                r_out.out_count <= r_pend_cnt;
            end else begin
                r_out.out_char  <= i_q_data.char0;
                r_out.run_last  <= !i_q_data.two;
                r_out.out_count <= i_q_data.cnt0;
                r_pend_cnt      <= i_q_data.cnt1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_out_valid <= 1'b1;
                r_pend      <= 1'b0;
            end else begin
                r_out_valid <= i_q_valid;
                r_pend      <= i_q_valid && i_q_data.two;
            end
        end
    end

    // While the LF is pending, the CR it follows must be on the output.
    a_pend_has_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_out_valid && !r_out.run_last))
        else $error("pending LF without its CR on the output");

    // The pending LF always appears as the closing result of its request.
    a_lf_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && load) |=> (r_out_valid && r_out.run_last
                              && r_out.out_char == esd_pkg::CH_LF))
        else $error("pending LF not presented as the last result");

    // A second byte is only ever owed for a two-byte request.
    a_pend_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_pend && o_q_pop && !i_q_data.two) |=> !r_pend)
        else $error("second byte owed for a single-byte request");

endmodule

@@ rtl/escape_sequence_decoder.sv @@
// Backslash escape decoder for character strings. One source character is
// taken per request on the input channel, with is_final marking the end of
// a string; decoded bytes leave on the output channel, each with run_last set
// on the final byte caused by its input and a running per-string byte count
// that saturates at 2^COUNT_BITS - 1 and returns to zero after each string.
// The block accepts one character every cycle while its queue is not full.
// Every input character yields at most one output byte, except the newline
// escape, which yields CR and LF. A four-entry queue between the classifying
// front and the output stage absorbs those extra bytes and any back-pressure;
// the input is only held off when that queue is full. A byte passes through
// the queue and then the registered output stage before it is presented on
// the output. Escape letters are matched as plain ASCII.
module escape_sequence_decoder #(
    parameter int COUNT_BITS = esd_pkg::COUNT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  esd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output esd_pkg::t_out o_out_data
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_valid;
    esd_pkg::t_entry q_wr_data;
    esd_pkg::t_entry q_rd_data;

    // The front tracks the escape phase and turns each character into a
    // request of zero, one or two bytes with their counts already worked out.
    esd_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wr_data)
    );

    // The queue decouples the two sides so that either may stall alone.
    esd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rd_data)
    );

    // The back drains requests into the registered output, presenting the
    // CR LF pair as two results, the CR first and the LF after it.
    esd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_rd_data),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ test/escape_sequence_decoder_checker.sv @@
`timescale 1ns / 1ps

module escape_sequence_decoder_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  esd_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  esd_pkg::t_out i_out_data,
    output int            o_mismatches,
    output int            o_outstanding
);
    import esd_pkg::*;

    typedef enum logic [2:0] {
        ST_PLAIN,
        ST_ESC,
        ST_HEX_HI,
        ST_HEX_LO,
        ST_DEC_HUNDREDS,
        ST_DEC_TENS,
        ST_DEC_UNITS
    } t_decode_phase;

    localparam logic [7:0] LETTER_N_LO = "n";
    localparam logic [7:0] LETTER_N_UP = "N";
    localparam logic [7:0] LETTER_T_LO = "t";
    localparam logic [7:0] LETTER_T_UP = "T";
    localparam logic [7:0] LETTER_X_LO = "x";
    localparam logic [7:0] LETTER_X_UP = "X";
    localparam logic [7:0] LETTER_I_LO = "i";
    localparam logic [7:0] LETTER_I_UP = "I";
    localparam int DIGIT_ZERO  = "0";
    localparam int DIGIT_NINE  = "9";
    localparam int LOWER_A     = "a";
    localparam int LOWER_Z     = "z";
    localparam int UPPER_A     = "A";
    localparam int UPPER_F     = "F";
    localparam int CASE_GAP    = 32;
    localparam int NO_HEX      = 16;
    localparam int NO_DEC      = 10;
    localparam int COUNT_CEILING = (1 << COUNT_BITS_DEF) - 1;
    localparam int REPORT_LIMIT  = 10;

    t_decode_phase dec_phase;
    logic [9:0]    digit_acc;
    logic          digit_invalid;
    int            string_bytes;
    int            mismatches;
    t_out          expected_bytes[$];
    t_out          step_bytes[$];

    function automatic int hex_digit_value(logic [7:0] c);
        int u;
        u = int'(c);
        if (u >= LOWER_A && u <= LOWER_Z)
            u = u - CASE_GAP;
        if (u >= DIGIT_ZERO && u <= DIGIT_NINE)
            return u - DIGIT_ZERO;
        if (u >= UPPER_A && u <= UPPER_F)
            return u - UPPER_A + 10;
        return NO_HEX;
    endfunction

    function automatic int dec_digit_value(logic [7:0] c);
        int u;
        u = int'(c);
        if (u >= DIGIT_ZERO && u <= DIGIT_NINE)
            return u - DIGIT_ZERO;
        return NO_DEC;
    endfunction

    task automatic emit_byte(logic [7:0] ch);
        t_out r;
        if (string_bytes < COUNT_CEILING)
            string_bytes++;
        r.out_char  = ch;
        r.run_last  = 1'b0;
        r.out_count = OUT_COUNT_W'(string_bytes);
        step_bytes.push_back(r);
    endtask

    // Advances the decoder by one character and queues the bytes it yields.
    task automatic decode_request(t_in req);
        int         v;
        int         code;
        logic [7:0] c;
        logic       trailing_bs;
        c = req.in_char;
        trailing_bs = 1'b0;
        step_bytes.delete();
        case (dec_phase)
            ST_PLAIN: begin
                if (c == CH_BACKSLASH) begin
                    dec_phase = ST_ESC;
                    trailing_bs = 1'b1;
                end else begin
                    emit_byte(c);
                end
            end
            ST_ESC: begin
                dec_phase = ST_PLAIN;
                digit_invalid = 1'b0;
                digit_acc = '0;
                if (c == CH_BACKSLASH || c == CH_QUOTE) begin
                    emit_byte(c);
                end else if (c == LETTER_N_LO || c == LETTER_N_UP) begin
                    emit_byte(CH_CR);
                    emit_byte(CH_LF);
                end else if (c == LETTER_T_LO || c == LETTER_T_UP) begin
                    emit_byte(CH_TAB);
                end else if (c == LETTER_X_LO || c == LETTER_X_UP) begin
                    dec_phase = ST_HEX_HI;
                end else if (c == LETTER_I_LO || c == LETTER_I_UP) begin
                    dec_phase = ST_DEC_HUNDREDS;
                end
            end
            ST_HEX_HI: begin
                v = hex_digit_value(c);
                if (v >= NO_HEX)
                    digit_invalid = 1'b1;
                else
                    digit_acc = 10'(v);
                dec_phase = ST_HEX_LO;
            end
            ST_HEX_LO: begin
                v = hex_digit_value(c);
                if (!digit_invalid && v < NO_HEX)
                    emit_byte({digit_acc[3:0], 4'(v)});
                dec_phase = ST_PLAIN;
            end
            ST_DEC_HUNDREDS: begin
                v = dec_digit_value(c);
                if (v >= NO_DEC)
                    digit_invalid = 1'b1;
                else
                    digit_acc = 10'(v * 100);
                dec_phase = ST_DEC_TENS;
            end
            ST_DEC_TENS: begin
                v = dec_digit_value(c);
                if (v >= NO_DEC)
                    digit_invalid = 1'b1;
                else if (!digit_invalid)
                    digit_acc = digit_acc + 10'(v * 10);
                dec_phase = ST_DEC_UNITS;
            end
            ST_DEC_UNITS: begin
                v = dec_digit_value(c);
                if (!digit_invalid && v < NO_DEC) begin
                    code = int'(digit_acc) + v;
                    if (code < 256)
                        emit_byte(8'(code));
                end
                dec_phase = ST_PLAIN;
            end
            default: begin
                dec_phase = ST_PLAIN;
            end
        endcase

        if (req.is_final) begin
            if (trailing_bs)
                emit_byte(CH_BACKSLASH);
            dec_phase = ST_PLAIN;
            digit_acc = '0;
            digit_invalid = 1'b0;
            string_bytes = 0;
        end

        if (step_bytes.size() > 0)
            step_bytes[step_bytes.size() - 1].run_last = 1'b1;
        foreach (step_bytes[k])
            expected_bytes.push_back(step_bytes[k]);
    endtask

    task automatic record_mismatch(string what, t_out want, t_out got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s: expected char %02h last %0b count %0d, got char %02h last %0b count %0d",
                     $realtime, what, want.out_char, want.run_last, want.out_count,
                     got.out_char, got.run_last, got.out_count);
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            dec_phase = ST_PLAIN;
            digit_acc = '0;
            digit_invalid = 1'b0;
            string_bytes = 0;
            mismatches = 0;
            expected_bytes.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                decode_request(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    want = '0;
                    record_mismatch("byte with none expected", want, i_out_data);
                end else begin
                    want = expected_bytes.pop_front();
                    if (want.out_char != i_out_data.out_char ||
                        want.run_last != i_out_data.run_last ||
                        want.out_count != i_out_data.out_count)
                        record_mismatch("byte mismatch", want, i_out_data);
                end
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= expected_bytes.size();
    end

endmodule

@@ test/escape_sequence_decoder_test.sv @@
`timescale 1ns / 1ps

module escape_sequence_decoder_test;
    import esd_pkg::*;

    // Roughly a third of the random characters go in each idling phase.
    localparam int PHASE_REQUESTS = 510;
    // Length of the long output stall that backs the queue up to the input.
    localparam int STALL_CYCLES   = 200;
    // Generous bound on the whole run; the slowest legal run is far shorter.
    localparam int CYCLE_LIMIT    = 400000;
    // Cycles allowed for the pipeline to drain once nothing is outstanding.
    localparam int DRAIN_CYCLES   = 8;

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    t_in   i_in_data   = '0;
    logic  i_out_ready = 1'b0;
    logic  o_in_ready;
    logic  o_out_valid;
    t_out  o_out_data;

    int    mismatches;
    int    outstanding;

    int    sender_idle_pct   = 0;
    int    receiver_idle_pct = 0;
    int    stall_requests    = 0;
    int    stall_served      = 0;
    int    stall_left        = 0;
    int    requests_sent     = 0;
    int    cycle_count       = 0;

    // Characters of the string being assembled for the next send.
    logic [7:0] text[$];

    always #5 i_clk = ~i_clk;

    escape_sequence_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // The checker follows both channels, predicts every decoded byte and
    // compares; all this module does is produce stimulus and give the verdict.
    escape_sequence_decoder_checker decode_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out_data    (o_out_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // A hung block must not hold the run up forever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver. Normally it takes results at the current idling rate, but when
    // the stimulus asks for a stall it refuses everything for a fixed number of
    // cycles, counted here, so that the internal queue fills and the input is
    // held off while the sender keeps offering characters.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_served != stall_requests) begin
            stall_served <= stall_requests;
            stall_left <= STALL_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Offers one character, with the sender's random gap in front of it, and
    // returns at the edge where the request is taken. Valid is left high so
    // that back-to-back requests need no second assignment in the same step.
    task automatic send_request(input logic [7:0] ch, input logic fin);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= {ch, fin};
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic put(input logic [7:0] ch);
        text.push_back(ch);
    endtask

    // Sends the assembled string, marking its last character as the end.
    task automatic send_text();
        foreach (text[k])
            send_request(text[k], k == text.size() - 1);
        text.delete();
    endtask

    // Any byte other than a backslash, mostly printable but now and then
    // from the whole range, zero and 0xFF among them.
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do begin
            if ($urandom_range(3) == 0)
                c = 8'($urandom_range(255));
            else
                c = 8'($urandom_range(32, 126));
        end while (c == CH_BACKSLASH);
        return c;
    endfunction

    // A hex digit in either case, and occasionally an arbitrary byte so that
    // the invalid digit path is taken too.
    function automatic logic [7:0] hex_digit_char();
        int v;
        v = $urandom_range(15);
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255));
        if (v < 10)
            return 8'("0" + v);
        return 8'(($urandom_range(1) ? "A" : "a") + v - 10);
    endfunction

    // Builds one random string out of mostly well-formed pieces: plain text,
    // every kind of escape, numeric escapes near the 256 boundary, unknown
    // escape letters and raw noise. Some strings are cut short so that they
    // end inside a pending escape, including right after a lone backslash.
    task automatic compose_random_string();
        int         pieces;
        int         pick;
        int         value;
        int         keep;
        logic [7:0] digits[3];
        pieces = $urandom_range(1, 12);
        repeat (pieces) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                put(plain_char());
            end else if (pick < 48) begin
                put(CH_BACKSLASH);
                put($urandom_range(1) ? CH_BACKSLASH : CH_QUOTE);
            end else if (pick < 55) begin
                put(CH_BACKSLASH);
                put($urandom_range(1) ? "n" : "N");
            end else if (pick < 61) begin
                put(CH_BACKSLASH);
                put($urandom_range(1) ? "t" : "T");
            end else if (pick < 75) begin
                put(CH_BACKSLASH);
                put($urandom_range(1) ? "x" : "X");
                put(hex_digit_char());
                put(hex_digit_char());
            end else if (pick < 89) begin
                if ($urandom_range(1))
                    value = $urandom_range(999);
                else
                    value = $urandom_range(240, 270);
                digits[0] = 8'("0" + value / 100);
                digits[1] = 8'("0" + (value / 10) % 10);
                digits[2] = 8'("0" + value % 10);
                if ($urandom_range(7) == 0)
                    digits[$urandom_range(2)] = 8'($urandom_range(255));
                put(CH_BACKSLASH);
                put($urandom_range(1) ? "i" : "I");
                foreach (digits[k])
                    put(digits[k]);
            end else if (pick < 94) begin
                // Mostly letters with no meaning after a backslash.
                put(CH_BACKSLASH);
                put(8'($urandom_range(32, 126)));
            end else begin
                put(8'($urandom_range(255)));
            end
        end
        if ($urandom_range(99) < 15) begin
            keep = $urandom_range(1, text.size());
            while (text.size() > keep)
                void'(text.pop_back());
        end
    endtask

    task automatic run_random_phase(input int quota);
        int target;
        target = requests_sent + quota;
        while (requests_sent < target) begin
            compose_random_string();
            send_text();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender lightly idle, receiver mostly stalling.
        sender_idle_pct = 18;
        receiver_idle_pct = 62;

        // Directed strings. A lone zero byte is an ordinary one-character
        // string. The second covers the top byte value, newline, quote, an
        // upper-case tab, an unknown escape letter and a string that ends on
        // a lone backslash. The third has upper-case hex with mixed-case
        // digits, a decimal escape just out of range and a final escaped
        // backslash. The last has the largest decimal byte and then ends in
        // the middle of a hex escape on an invalid digit.
        put(8'h00);
        send_text();
        put(8'hFF); put(CH_BACKSLASH); put("n"); put(CH_BACKSLASH); put(CH_QUOTE);
        put(CH_BACKSLASH); put("T"); put(CH_BACKSLASH); put("q"); put(CH_BACKSLASH);
        send_text();
        put(CH_BACKSLASH); put("X"); put("f"); put("F");
        put(CH_BACKSLASH); put("i"); put("2"); put("5"); put("6");
        put(CH_BACKSLASH); put(CH_BACKSLASH);
        send_text();
        put(CH_BACKSLASH); put("I"); put("2"); put("5"); put("5");
        put(CH_BACKSLASH); put("x"); put("g");
        send_text();

        run_random_phase(PHASE_REQUESTS);

        // The other way round: the sender is slow and the receiver eager.
        sender_idle_pct = 62;
        receiver_idle_pct = 18;
        run_random_phase(PHASE_REQUESTS);

        // No idling at all, opening with one long output stall so that the
        // queue fills and the input is backed up.
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        stall_requests = stall_requests + 1;
        run_random_phase(PHASE_REQUESTS);

        i_in_valid <= 1'b0;

        // The outstanding count is registered, so step once before
        // looking at it.
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
